>>> design/tptb_pkg.sv
package tptb_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_W     = 3;
   localparam int CMP_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int ACTION_W   = 3;
   localparam int TIME_W     = 31;
   localparam int DUE_W      = 32;
   localparam int PERIOD_W   = 32;
   localparam int MASK_W     = 8;
   localparam int OCC_W      = 4;

   localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSTALL  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INTERVAL = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ENABLE   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

   typedef struct packed {
      logic              used;
      logic              enabled;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] prev_run;
      logic [DUE_W-1:0]  next_due;
   } slot_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [SLOT_W-1:0]         slot;
      logic [TIME_W-1:0]         now_ms;
      logic signed [PERIOD_W-1:0] period;
      logic                      enable_bit;
   } op_type;

   typedef struct packed {
      logic fire;
      logic inc;
      logic dec;
      logic clear;
   } status_type;

endpackage

>>> design/tptb_if.sv
interface tptb_req_if import tptb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [SLOT_W-1:0]          slot;
   logic [TIME_W-1:0]          now_ms;
   logic signed [PERIOD_W-1:0] period;
   logic                       enable_bit;

   modport source (output valid, action, slot, now_ms, period, enable_bit, input ready);
   modport sink (input valid, action, slot, now_ms, period, enable_bit, output ready);
endinterface

interface tptb_rsp_if import tptb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] fired_mask;
   logic [OCC_W-1:0]  occupied_count;

   modport source (output valid, fired_mask, occupied_count, input ready);
   modport sink (input valid, fired_mask, occupied_count, output ready);
endinterface

>>> design/tptb_cell.sv
module tptb_cell import tptb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  slot_type slot_d,
   output slot_type slot_q
);

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (shift_en) begin
         slot_in = slot_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_q = slot_ff;

endmodule

>>> design/tptb_slot_op.sv
module tptb_slot_op import tptb_pkg::*; (
   input  op_type     op,
   input  logic       hit,
   input  slot_type   cur,
   output slot_type   nxt,
   output status_type status
);

   logic [TIME_W-1:0] per;

   // Negative intervals clamp to zero.
   assign per = op.period[PERIOD_W-1] ? '0 : op.period[TIME_W-1:0];

   always_comb begin
      nxt    = cur;
      status = '0;
      unique case (op.action)
         ACT_TICK: begin
            if (cur.used && cur.enabled && ({1'b0, op.now_ms} >= cur.next_due)) begin
               status.fire  = 1'b1;
               nxt.prev_run = op.now_ms;
               nxt.next_due = {1'b0, op.now_ms} + {1'b0, cur.period};
            end
         end
         ACT_INSTALL: begin
            if (hit) begin
               status.inc   = !cur.used;
               nxt.used     = 1'b1;
               nxt.enabled  = op.enable_bit;
               nxt.period   = per;
               nxt.prev_run = '0;
               nxt.next_due = {1'b0, per};
            end
         end
         ACT_INTERVAL: begin
            if (hit && cur.used) begin
               nxt.period   = per;
               nxt.next_due = {1'b0, cur.prev_run} + {1'b0, per};
            end
         end
         ACT_ENABLE: begin
            if (hit && cur.used) begin
               nxt.enabled = op.enable_bit;
            end
         end
         ACT_REMOVE: begin
            if (hit && cur.used) begin
               status.dec = 1'b1;
               nxt.used   = 1'b0;
            end
         end
         ACT_CLEAR: begin
            status.clear = 1'b1;
            nxt          = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> design/periodic_task_timer_bank.sv
// Bank of periodic task slots driven by a request and a response channel.
// Each request transfer carries an action (tick, install, set interval,
// set enable, remove, clear all) with its slot index, time and interval.
// Every request yields exactly one response transfer: the mask of slots
// that fired on a tick (zero for other actions) and the occupied count.
// The slots sit in a ring of cells that rotates by one place per cycle
// while a request runs; the head cell passes through the slot update
// logic, so one slot is examined per cycle. A request makes one full
// pass of the ring and then loads the response register; the bank takes
// no new request until the current one has loaded its response.
// A new request is accepted while a finished response still waits.
// If the receiver stalls, the next finished result waits until the
// response register is free, and no further request is accepted meanwhile.
// Reset clears every slot, the occupied count and the response valid flag.
module periodic_task_timer_bank import tptb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tptb_req_if.sink     req,
   tptb_rsp_if.source   rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_COUNT-1:0] fired_ff, fired_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   slot_type   cell_d [SLOT_COUNT];
   slot_type   cell_q [SLOT_COUNT];
   slot_type   head_next;
   status_type status;
   logic       hit;
   logic       running;
   logic       last_step;
   logic       req_xfer;

   assign running   = (state_ff == ST_RUN);
   assign last_step = (cnt_ff == IDX_W'(SLOT_COUNT - 1));
   assign req_xfer  = req.valid && req.ready;
   assign hit       = (CMP_W'(op_ff.slot) == CMP_W'(cnt_ff));

   // Slot k sits at the head after k rotations; after a full pass the ring
   // is back in its original order.
   always_comb begin
      for (int i = 0; i < SLOT_COUNT - 1; i++) begin
         cell_d[i] = cell_q[i + 1];
      end
      cell_d[SLOT_COUNT - 1] = head_next;
   end

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      tptb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (running),
         .slot_d   (cell_d[g]),
         .slot_q   (cell_q[g])
      );
   end

   tptb_slot_op u_slot_op (
      .op     (op_ff),
      .hit    (hit),
      .cur    (cell_q[0]),
      .nxt    (head_next),
      .status (status)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      fired_in     = fired_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_occ_in   = rsp_occ_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in.action     = req.action;
               op_in.slot       = req.slot;
               op_in.now_ms     = req.now_ms;
               op_in.period     = req.period;
               op_in.enable_bit = req.enable_bit;
               cnt_in           = '0;
               state_in         = ST_RUN;
            end
         end
         ST_RUN: begin
            // Fire bits enter at the top and reach their slot's place after
            // the full pass.
            fired_in = fired_ff >> 1;
            fired_in[SLOT_COUNT - 1] = status.fire;
            priority if (status.clear) begin
               count_in = '0;
            end else if (status.inc) begin
               count_in = count_ff + CNT_W'(1);
            end else if (status.dec) begin
               count_in = count_ff - CNT_W'(1);
            end
            cnt_in = cnt_ff + IDX_W'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = MASK_W'(fired_ff);
               rsp_occ_in   = OCC_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      fired_ff    <= fired_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_occ_ff  <= rsp_occ_in;
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.fired_mask     = rsp_mask_ff;
   assign rsp.occupied_count = rsp_occ_ff;

endmodule
